/* hdl/qmi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared widths, codes and controller/datapath interface types for the
// queue with middle insertion.
// ----------------------------------------------------------------------------
package qmi_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W           = 32;
    localparam int ACT_W            = 2;
    localparam int STAT_W           = 2;
    localparam int OCC_W            = 7;

    localparam logic [ACT_W-1:0] ACT_PUSH_BACK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_MID  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP       = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Queue is kept as front half F followed by back half B,
    // with |F| = ceil(n/2) and |B| = floor(n/2) at rest.
    typedef enum logic [3:0] {
        OP_IGNORE,
        OP_FULL,
        OP_EMPTY,
        OP_PB_DIRECT,   // empty queue: value goes straight to F
        OP_PB_PLAIN,    // odd count: append to B
        OP_PB_MOVE,     // even count: append to B, move B front to F tail
        OP_MID_PLAIN,   // even count: append to F
        OP_MID_B_FRONT, // odd count: value becomes the new B front
        OP_POP_PLAIN,   // odd count: pop F front
        OP_POP_MOVE     // even count: pop F front, move B front to F tail
    } op_t;

    typedef struct packed {
        logic issue;    // transaction accepted this cycle, first memory step
        logic finish;   // second memory step, result is formed
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic even;
    } dp_status_t;

endpackage

/* hdl/qmi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/qmi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_ctrl
// Controller: input/output handshake and the two-step sequence per
// transaction.
// ----------------------------------------------------------------------------
module qmi_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [qmi_pkg::ACT_W-1:0] action,
    output logic                      out_valid,
    input  logic                      out_stall,
    input  qmi_pkg::dp_status_t       dp_status,
    output qmi_pkg::cmd_t             cmd
);

    typedef enum logic {
        IDLE,
        WORK
    } state_t;

    state_t        state_reg;
    qmi_pkg::op_t  op_reg;
    qmi_pkg::op_t  op_next;
    logic          out_valid_reg;
    logic          ready;
    logic          accept;

    always_comb
    begin
        op_next = qmi_pkg::OP_IGNORE;
        case (action)
            qmi_pkg::ACT_PUSH_BACK:
            begin
                if (dp_status.full)
                    op_next = qmi_pkg::OP_FULL;
                else if (dp_status.empty)
                    op_next = qmi_pkg::OP_PB_DIRECT;
                else if (dp_status.even)
                    op_next = qmi_pkg::OP_PB_MOVE;
                else
                    op_next = qmi_pkg::OP_PB_PLAIN;
            end
            qmi_pkg::ACT_PUSH_MID:
            begin
                if (dp_status.full)
                    op_next = qmi_pkg::OP_FULL;
                else if (dp_status.even)
                    op_next = qmi_pkg::OP_MID_PLAIN;
                else
                    op_next = qmi_pkg::OP_MID_B_FRONT;
            end
            qmi_pkg::ACT_POP:
            begin
                if (dp_status.empty)
                    op_next = qmi_pkg::OP_EMPTY;
                else if (dp_status.even)
                    op_next = qmi_pkg::OP_POP_MOVE;
                else
                    op_next = qmi_pkg::OP_POP_PLAIN;
            end
            default:
            begin
                op_next = qmi_pkg::OP_IGNORE;
            end
        endcase
    end

    // idle, and the result slot is free or is emptied at this edge
    assign ready     = (state_reg == IDLE) && (!out_valid_reg || !out_stall);
    assign in_stall  = !ready;
    assign accept    = in_valid && ready;
    assign out_valid = out_valid_reg;

    assign cmd.issue  = accept;
    assign cmd.finish = (state_reg == WORK);
    assign cmd.op     = (state_reg == IDLE) ? op_next : op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            op_reg        <= qmi_pkg::OP_IGNORE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (out_valid_reg && !out_stall)
                        out_valid_reg <= 1'b0;
                    if (accept)
                    begin
                        op_reg    <= op_next;
                        state_reg <= WORK;
                    end
                end
                WORK:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    a_issue_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> cmd.finish)
        else $error("second step did not follow an accepted transaction");

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid && !cmd.finish))
        else $error("result not presented after second step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid)
        else $error("result register overwritten while still pending");

endmodule

/* hdl/qmi_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_dp
// Datapath: front-half and back-half ring buffers, pointers, count and
// result register.
// ----------------------------------------------------------------------------
module qmi_dp #(
    parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qmi_pkg::cmd_t                     cmd,
    input  logic signed [qmi_pkg::DATA_W-1:0] value,
    output qmi_pkg::dp_status_t               dp_status,
    output logic signed [qmi_pkg::DATA_W-1:0] front_value,
    output logic [qmi_pkg::STAT_W-1:0]        status,
    output logic [qmi_pkg::OCC_W-1:0]         occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = qmi_pkg::DATA_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] f_head_reg;
    logic [AW-1:0] f_head_next;
    logic [AW-1:0] b_head_reg;
    logic [AW-1:0] b_head_next;
    logic [DW-1:0] value_reg;

    logic signed [DW-1:0]          front_reg;
    logic [qmi_pkg::STAT_W-1:0]    status_reg;
    logic [qmi_pkg::OCC_W-1:0]     occ_reg;

    logic [CW-1:0] f_cnt;
    logic [CW-1:0] b_cnt;
    logic [AW-1:0] f_tail;
    logic [AW-1:0] b_tail;

    logic          f_wr_en, f_rd_en, b_wr_en, b_rd_en;
    logic [AW-1:0] f_wr_addr, f_rd_addr, b_wr_addr, b_rd_addr;
    logic [DW-1:0] f_wr_data, b_wr_data, f_rd_data, b_rd_data;

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
        logic [PW-1:0] s;
        s = {1'b0, p} + PW'(n);
        if (s >= PW'(CAPACITY))
            s = s - PW'(CAPACITY);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
    endfunction

    assign f_cnt  = (count_reg + 1'b1) >> 1;
    assign b_cnt  = count_reg >> 1;
    assign f_tail = ptr_add(f_head_reg, f_cnt);
    assign b_tail = ptr_add(b_head_reg, b_cnt);

    assign dp_status.empty = (count_reg == '0);
    assign dp_status.full  = (count_reg >= CW'(CAPACITY));
    assign dp_status.even  = !count_reg[0];

    // memory port steering for both steps of a transaction
    always_comb
    begin
        f_wr_en   = 1'b0;
        f_wr_addr = f_tail;
        f_wr_data = value;
        f_rd_en   = 1'b0;
        f_rd_addr = f_head_reg;
        b_wr_en   = 1'b0;
        b_wr_addr = b_tail;
        b_wr_data = value;
        b_rd_en   = 1'b0;
        b_rd_addr = b_head_reg;
        if (cmd.issue)
        begin
            case (cmd.op)
                qmi_pkg::OP_PB_DIRECT,
                qmi_pkg::OP_MID_PLAIN:
                begin
                    f_wr_en = 1'b1;
                end
                qmi_pkg::OP_PB_PLAIN:
                begin
                    b_wr_en = 1'b1;
                end
                qmi_pkg::OP_PB_MOVE:
                begin
                    b_wr_en = 1'b1;
                    b_rd_en = 1'b1;
                end
                qmi_pkg::OP_POP_PLAIN:
                begin
                    f_rd_en = 1'b1;
                end
                qmi_pkg::OP_POP_MOVE:
                begin
                    f_rd_en = 1'b1;
                    b_rd_en = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.finish)
        begin
            case (cmd.op)
                qmi_pkg::OP_PB_MOVE,
                qmi_pkg::OP_POP_MOVE:
                begin
                    // pop keeps the old head here, so f_tail is the new tail slot
                    f_wr_en   = 1'b1;
                    f_wr_data = b_rd_data;
                end
                qmi_pkg::OP_MID_B_FRONT:
                begin
                    b_wr_en   = 1'b1;
                    b_wr_addr = ptr_dec(b_head_reg);
                    b_wr_data = value_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        f_head_next = f_head_reg;
        b_head_next = b_head_reg;
        case (cmd.op)
            qmi_pkg::OP_PB_DIRECT,
            qmi_pkg::OP_PB_PLAIN,
            qmi_pkg::OP_MID_PLAIN:
            begin
                count_next = count_reg + 1'b1;
            end
            qmi_pkg::OP_PB_MOVE:
            begin
                count_next  = count_reg + 1'b1;
                b_head_next = ptr_inc(b_head_reg);
            end
            qmi_pkg::OP_MID_B_FRONT:
            begin
                count_next  = count_reg + 1'b1;
                b_head_next = ptr_dec(b_head_reg);
            end
            qmi_pkg::OP_POP_PLAIN:
            begin
                count_next  = count_reg - 1'b1;
                f_head_next = ptr_inc(f_head_reg);
            end
            qmi_pkg::OP_POP_MOVE:
            begin
                count_next  = count_reg - 1'b1;
                f_head_next = ptr_inc(f_head_reg);
                b_head_next = ptr_inc(b_head_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            f_head_reg <= '0;
            b_head_reg <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg  <= count_next;
            f_head_reg <= f_head_next;
            b_head_reg <= b_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            value_reg <= value;
        end
        if (cmd.finish)
        begin
            occ_reg <= qmi_pkg::OCC_W'(count_next);
            if (cmd.op == qmi_pkg::OP_POP_PLAIN || cmd.op == qmi_pkg::OP_POP_MOVE)
                front_reg <= f_rd_data;
            else
                front_reg <= '0;
            if (cmd.op == qmi_pkg::OP_FULL)
                status_reg <= qmi_pkg::ST_FULL;
            else if (cmd.op == qmi_pkg::OP_EMPTY)
                status_reg <= qmi_pkg::ST_EMPTY;
            else
                status_reg <= qmi_pkg::ST_OK;
        end
    end

    assign front_value = front_reg;
    assign status      = status_reg;
    assign occupancy   = occ_reg;

    qmi_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_front_ram (
        .clk     (clk),
        .wr_en   (f_wr_en),
        .wr_addr (f_wr_addr),
        .wr_data (f_wr_data),
        .rd_en   (f_rd_en),
        .rd_addr (f_rd_addr),
        .rd_data (f_rd_data)
    );

    qmi_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_back_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && (cmd.op == qmi_pkg::OP_POP_PLAIN || cmd.op == qmi_pkg::OP_POP_MOVE))
        |-> (count_reg != '0))
        else $error("pop issued on an empty queue");

endmodule

/* hdl/queue_with_middle_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// Bounded queue of signed values with push-back, push-middle and pop-front.
// ----------------------------------------------------------------------------
// Each transaction runs in an issue step and a finish step: the queue is held
// as a front half and a back half in two RAMs, and keeping the halves balanced
// may move one entry between them, a read on one RAM's registered read port
// followed by a write into the other. One result comes out per transaction;
// while a result waits under out_stall the next transaction is held off, else
// a new one is taken once the last has finished. No clearing pass after reset.
module queue_with_middle_insert #(
    parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [qmi_pkg::ACT_W-1:0]         action,
    input  logic signed [qmi_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [qmi_pkg::DATA_W-1:0] front_value,
    output logic [qmi_pkg::STAT_W-1:0]        status,
    output logic [qmi_pkg::OCC_W-1:0]         occupancy
);

    qmi_pkg::cmd_t       cmd;
    qmi_pkg::dp_status_t dp_status;

    qmi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    qmi_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (value),
        .dp_status   (dp_status),
        .front_value (front_value),
        .status      (status),
        .occupancy   (occupancy)
    );

endmodule

/* tb/sv/tb_queue_with_middle_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_queue_with_middle_insert
// Self-checking bench for the bounded queue with middle insertion.
// ----------------------------------------------------------------------------
// A clocked driver feeds push-back, push-middle, pop and unused-code
// transactions from a pending list. A clocked monitor mirrors the queue
// contents in a SystemVerilog queue and checks every result field in
// order. A short directed sequence is followed by random fill, drain and
// mixed runs, under four idle/stall phases on both channels.
// ----------------------------------------------------------------------------
module tb_queue_with_middle_insert;

    localparam int CAPACITY = qmi_pkg::DEFAULT_CAPACITY;
    localparam logic [qmi_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_LEN    = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [qmi_pkg::ACT_W-1:0]         act;
        logic signed [qmi_pkg::DATA_W-1:0] val;
        int                                phase;
    } action_item_t;

    typedef struct {
        logic [qmi_pkg::ACT_W-1:0]         act;
        logic signed [qmi_pkg::DATA_W-1:0] front_value;
        logic [qmi_pkg::STAT_W-1:0]        status;
        logic [qmi_pkg::OCC_W-1:0]         occupancy;
    } queue_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [qmi_pkg::ACT_W-1:0]         action = '0;
    logic signed [qmi_pkg::DATA_W-1:0] value = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [qmi_pkg::DATA_W-1:0] front_value;
    logic [qmi_pkg::STAT_W-1:0]        status;
    logic [qmi_pkg::OCC_W-1:0]         occupancy;

    action_item_t                      pending_actions[$];
    queue_result_t                     expected_results[$];
    logic signed [qmi_pkg::DATA_W-1:0] mirror_q[$];

    int drv_phase = 0;
    int total_items = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_mid = 0;
    int max_occ = 0;
    int cycle_count = 0;

    queue_with_middle_insert #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .front_value (front_value),
        .status      (status),
        .occupancy   (occupancy)
    );

    always #5 clk = ~clk;

    function automatic int send_idle_pct(int ph);
        case (ph)
            1: return 88;
            3: return 30;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(int ph);
        case (ph)
            2: return 88;
            3: return 30;
            default: return 0;
        endcase
    endfunction

    // Applies one transaction to the mirror and returns what the block must report.
    function automatic queue_result_t apply_action(logic [qmi_pkg::ACT_W-1:0] act,
                                                   logic signed [qmi_pkg::DATA_W-1:0] val);
        queue_result_t r;
        int            pos;
        r.act = act;
        r.front_value = '0;
        r.status = qmi_pkg::ST_OK;
        if (act == qmi_pkg::ACT_PUSH_BACK || act == qmi_pkg::ACT_PUSH_MID)
        begin
            if (mirror_q.size() >= CAPACITY)
            begin
                r.status = qmi_pkg::ST_FULL;
            end
            else if (act == qmi_pkg::ACT_PUSH_MID)
            begin
                pos = (mirror_q.size() + 1) / 2;
                mirror_q.insert(pos, val);
            end
            else
            begin
                mirror_q.push_back(val);
            end
        end
        else if (act == qmi_pkg::ACT_POP)
        begin
            if (mirror_q.size() == 0)
                r.status = qmi_pkg::ST_EMPTY;
            else
                r.front_value = mirror_q.pop_front();
        end
        r.occupancy = qmi_pkg::OCC_W'(mirror_q.size());
        return r;
    endfunction

    task automatic add_item(logic [qmi_pkg::ACT_W-1:0] act,
                            logic signed [qmi_pkg::DATA_W-1:0] val, int ph);
        action_item_t it;
        it.act = act;
        it.val = val;
        it.phase = ph;
        pending_actions.push_back(it);
        total_items++;
    endtask

    function automatic logic signed [qmi_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $signed($urandom());
        endcase
    endfunction

    // Driver: holds a transaction until accepted, idles at random per phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= '0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                void'(pending_actions.pop_front());
            if (!(in_valid && in_stall))
            begin
                if (pending_actions.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct(pending_actions[0].phase))
                begin
                    in_valid  <= 1'b1;
                    action    <= pending_actions[0].act;
                    value     <= pending_actions[0].val;
                    drv_phase <= pending_actions[0].phase;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results first, then predicts the transaction taken this edge.
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_checked++;
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: unexpected result front=%0d status=%0d occ=%0d",
                                 front_value, status, occupancy);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (front_value !== exp_r.front_value || status !== exp_r.status ||
                        occupancy !== exp_r.occupancy)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                        begin
                            $display("ERROR: #%0d act %0d exp front=%0d status=%0d occ=%0d",
                                     n_checked, exp_r.act, exp_r.front_value,
                                     exp_r.status, exp_r.occupancy);
                            $display("       got front=%0d status=%0d occ=%0d",
                                     front_value, status, occupancy);
                        end
                    end
                    if (exp_r.status == qmi_pkg::ST_FULL)
                        n_full++;
                    if (exp_r.status == qmi_pkg::ST_EMPTY)
                        n_empty++;
                    if (exp_r.act == qmi_pkg::ACT_PUSH_MID && exp_r.status == qmi_pkg::ST_OK)
                        n_mid++;
                    if (int'(exp_r.occupancy) > max_occ)
                        max_occ = int'(exp_r.occupancy);
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_action(action, value));
                n_accepted++;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct(drv_phase));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d of %0d transactions accepted",
                     cycle_count, n_accepted, total_items);
            $display("tb_queue_with_middle_insert NOT OK");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int seg_len;
        int push_pct;
        int ph;
        int k;
        int n_rand;

        // directed: empty pop, unused code, extremes, middle positions
        add_item(qmi_pkg::ACT_POP,       32'sd5,          0);
        add_item(ACT_UNUSED,             32'sh7FFF_FFFF,  0);
        add_item(qmi_pkg::ACT_PUSH_MID,  32'sh7FFF_FFFF,  0);
        add_item(qmi_pkg::ACT_PUSH_MID,  32'sh8000_0000,  0);
        add_item(qmi_pkg::ACT_PUSH_BACK, -32'sd1,         0);
        add_item(qmi_pkg::ACT_PUSH_MID,  32'sd0,          0);
        add_item(qmi_pkg::ACT_PUSH_BACK, 32'sh5555_AAAA,  0);
        add_item(qmi_pkg::ACT_PUSH_MID,  32'shAAAA_5555,  0);
        add_item(ACT_UNUSED,             32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sh7FFF_FFFF,  0);
        add_item(qmi_pkg::ACT_PUSH_MID,  32'sd17,         0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);
        add_item(qmi_pkg::ACT_PUSH_BACK, 32'sh8000_0000,  0);
        add_item(qmi_pkg::ACT_POP,       32'sd0,          0);

        // random: fill, drain and mixed runs so that full and empty both recur
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            mode = $urandom_range(2);
            seg_len = $urandom_range(120, 20);
            push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (k = 0; k < seg_len; k++)
            begin
                ph = (n_rand / PHASE_LEN) % 4;
                if ($urandom_range(99) < 3)
                    add_item(ACT_UNUSED, rand_value(), ph);
                else if ($urandom_range(99) < push_pct)
                    add_item($urandom_range(1) ? qmi_pkg::ACT_PUSH_MID
                                               : qmi_pkg::ACT_PUSH_BACK,
                             rand_value(), ph);
                else
                    add_item(qmi_pkg::ACT_POP, rand_value(), ph);
                n_rand++;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d transactions, %0d errors.",
                 n_checked, total_items, n_errors);
        $display("Middle inserts %0d, full drops %0d, empty pops %0d, peak occupancy %0d.",
                 n_mid, n_full, n_empty, max_occ);
        if (n_errors == 0)
            $display("tb_queue_with_middle_insert OK");
        else
            $display("tb_queue_with_middle_insert NOT OK");
        $finish;
    end

endmodule
